// ===== rtl/tlbcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the clock-replacement translation buffer fill core.
package tlbcr_pkg;

    localparam int PAGE_W  = 25;
    localparam int FRAME_W = 8;
    localparam int ADDR_W  = 32;
    localparam int SLOT_W  = 2;

    // Request kinds carried on the slave-side tuser
    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_MARK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               dirty;
        logic               read_only;
    } entry_t;

endpackage

// ===== rtl/tlbcr_entry_ram.sv =====
`timescale 1ns / 1ps
// Entry store: page, frame and flag bits of each slot, one write and one registered read port.
module tlbcr_entry_ram #(
    parameter int ENTRIES = 4
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(ENTRIES)-1:0]        wr_addr,
    input  tlbcr_pkg::entry_t                 wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(ENTRIES)-1:0]        rd_addr,
    output logic [tlbcr_pkg::PAGE_W-1:0]      rd_page
);

    tlbcr_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_page <= mem[rd_addr].page;
        end
    end

endmodule

// ===== rtl/tlb_clock_replacement_fill_core.sv =====
`timescale 1ns / 1ps
// Top level of the clock-replacement translation buffer fill core.
//
// The core keeps TLB_ENTRIES translation slots and a clock hand. A fill request
// (tuser = fill) sweeps from the hand, one slot per cycle, clearing the use bit
// of each valid, used slot, and stops on the first invalid or unused slot. It
// writes the new entry there, parks the hand on it and returns the slot and
// the evicted page (zero when nothing valid was replaced). A mark request sets
// the use bit of hit_slot and echoes the slot. Valid and use bits sit in
// flip-flops cleared by reset; page, frame and flags live in a synchronous
// entry RAM whose contents are undefined until written; its page is reported
// only for valid slots. Requests are handled one at a time: a fill passes
// through accept, one sweep step per slot looked at (up to TLB_ENTRIES + 1),
// then the write-back step, which waits for a free result register and takes
// the victim's page from the registered RAM read issued as the sweep stops.
// A mark goes from accept to the write-back step. The result sits in an output
// register, so the next request is accepted while the previous result waits.
module tlb_clock_replacement_fill_core #(
    parameter int TLB_ENTRIES = 4,
    parameter int PAGE_BYTES  = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, low bit up: virt_addr[31:0], phys_frame[39:32], read_only[40],
    // dirty_in[41], hit_slot[43:42], zero fill[47:44]
    input  logic [47:0] s_tdata,
    // s_tuser: command[0] (0 = fill on miss, 1 = mark slot referenced)
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, low bit up: slot[1:0], evicted_valid[2], evicted_page[27:3],
    // zero fill[31:28]
    output logic [31:0] m_tdata
);

    localparam int IDX_W      = $clog2(TLB_ENTRIES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    // Unpacked request fields
    logic                               in_cmd;
    logic [tlbcr_pkg::ADDR_W-1:0]       in_virt_addr;
    logic [tlbcr_pkg::FRAME_W-1:0]      in_phys_frame;
    logic                               in_read_only;
    logic                               in_dirty;
    logic [tlbcr_pkg::SLOT_W-1:0]       in_hit_slot;

    assign in_cmd        = s_tuser[0];
    assign in_virt_addr  = s_tdata[31:0];
    assign in_phys_frame = s_tdata[39:32];
    assign in_read_only  = s_tdata[40];
    assign in_dirty      = s_tdata[41];
    assign in_hit_slot   = s_tdata[43:42];

    // Control state
    tlbcr_pkg::state_t                  state_reg, state_next;
    logic [TLB_ENTRIES-1:0]             valid_reg, valid_next;
    logic [TLB_ENTRIES-1:0]             use_reg, use_next;
    logic [IDX_W-1:0]                   hand_reg, hand_next;
    logic [IDX_W-1:0]                   pos_reg, pos_next;
    logic                               m_tvalid_reg, m_tvalid_next;

    // Request payload held during the sweep
    logic                               cmd_reg, cmd_next;
    logic [tlbcr_pkg::PAGE_W-1:0]       page_reg, page_next;
    logic [tlbcr_pkg::FRAME_W-1:0]      frame_reg, frame_next;
    logic                               ro_reg, ro_next;
    logic                               dirty_reg, dirty_next;
    logic [tlbcr_pkg::SLOT_W-1:0]       hit_slot_reg, hit_slot_next;

    // Result register
    logic [tlbcr_pkg::SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic                               res_ev_valid_reg, res_ev_valid_next;
    logic [tlbcr_pkg::PAGE_W-1:0]       res_ev_page_reg, res_ev_page_next;

    // Handshake and datapath control
    logic                               accept;
    logic                               out_free;
    logic                               cur_used;
    logic                               mark_in_range;
    logic [IDX_W-1:0]                   mark_idx;
    logic                               ram_rd_en;
    logic                               ram_wr_en;
    logic [tlbcr_pkg::PAGE_W-1:0]       ram_rd_page;
    tlbcr_pkg::entry_t                  ram_wr_data;

    assign s_tready      = (state_reg == tlbcr_pkg::ST_IDLE);
    assign accept        = s_tvalid && s_tready;
    // The result register can take a new result when empty or being drained
    assign out_free      = !m_tvalid_reg || m_tready;
    // Slot under the hand earns a second chance when it is valid and used
    assign cur_used      = valid_reg[pos_reg] && use_reg[pos_reg];
    assign mark_in_range = (int'(in_hit_slot) < TLB_ENTRIES);
    assign mark_idx      = IDX_W'(in_hit_slot);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, res_ev_page_reg, res_ev_valid_reg, res_slot_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tlbcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_cmd == tlbcr_pkg::CMD_MARK) ? tlbcr_pkg::ST_FINISH
                                                                 : tlbcr_pkg::ST_SWEEP;
                end
            end
            tlbcr_pkg::ST_SWEEP:
            begin
                if (!cur_used)
                begin
                    state_next = tlbcr_pkg::ST_FINISH;
                end
            end
            tlbcr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = tlbcr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbcr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values
    always_comb
    begin
        valid_next        = valid_reg;
        use_next          = use_reg;
        hand_next         = hand_reg;
        pos_next          = pos_reg;
        m_tvalid_next     = m_tvalid_reg;
        cmd_next          = cmd_reg;
        page_next         = page_reg;
        frame_next        = frame_reg;
        ro_next           = ro_reg;
        dirty_next        = dirty_reg;
        hit_slot_next     = hit_slot_reg;
        res_slot_next     = res_slot_reg;
        res_ev_valid_next = res_ev_valid_reg;
        res_ev_page_next  = res_ev_page_reg;
        ram_rd_en         = 1'b0;
        ram_wr_en         = 1'b0;

        // Drain the result register
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            tlbcr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = in_cmd;
                    page_next     = tlbcr_pkg::PAGE_W'(in_virt_addr >> PAGE_SHIFT);
                    frame_next    = in_phys_frame;
                    ro_next       = in_read_only;
                    dirty_next    = in_dirty;
                    hit_slot_next = in_hit_slot;
                    pos_next      = hand_reg;
                    // Mark takes effect at once; slots beyond the buffer are ignored
                    if (in_cmd == tlbcr_pkg::CMD_MARK && mark_in_range)
                    begin
                        use_next[mark_idx] = 1'b1;
                    end
                end
            end
            tlbcr_pkg::ST_SWEEP:
            begin
                if (cur_used)
                begin
                    // Second chance: clear use and advance the hand with wrap
                    use_next[pos_reg] = 1'b0;
                    pos_next = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
                end
                else
                begin
                    // Victim found: fetch its page for the eviction report
                    ram_rd_en = 1'b1;
                end
            end
            tlbcr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (cmd_reg == tlbcr_pkg::CMD_MARK)
                    begin
                        res_slot_next     = hit_slot_reg;
                        res_ev_valid_next = 1'b0;
                        res_ev_page_next  = '0;
                    end
                    else
                    begin
                        ram_wr_en          = 1'b1;
                        res_slot_next      = tlbcr_pkg::SLOT_W'(pos_reg);
                        res_ev_valid_next  = valid_reg[pos_reg];
                        res_ev_page_next   = valid_reg[pos_reg] ? ram_rd_page : '0;
                        valid_next[pos_reg] = 1'b1;
                        use_next[pos_reg]   = 1'b1;
                        hand_next           = pos_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ram_wr_data.page      = page_reg;
    assign ram_wr_data.frame     = frame_reg;
    assign ram_wr_data.dirty     = dirty_reg;
    assign ram_wr_data.read_only = ro_reg;

    tlbcr_entry_ram #(
        .ENTRIES (TLB_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_reg),
        .rd_page (ram_rd_page)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tlbcr_pkg::ST_IDLE;
            valid_reg    <= '0;
            use_reg      <= '0;
            hand_reg     <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            cmd_reg      <= tlbcr_pkg::CMD_FILL;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            use_reg      <= use_next;
            hand_reg     <= hand_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
            cmd_reg      <= cmd_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        page_reg         <= page_next;
        frame_reg        <= frame_next;
        ro_reg           <= ro_next;
        dirty_reg        <= dirty_next;
        hit_slot_reg     <= hit_slot_next;
        res_slot_reg     <= res_slot_next;
        res_ev_valid_reg <= res_ev_valid_next;
        res_ev_page_reg  <= res_ev_page_next;
    end

    // A completed fill leaves the hand on a valid, used slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlbcr_pkg::ST_FINISH && out_free && cmd_reg == tlbcr_pkg::CMD_FILL)
        |=> (valid_reg[hand_reg] && use_reg[hand_reg]))
    else $error("fill did not leave a valid, used slot under the hand");

    // The sweep only stops on a slot that is invalid or unused
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlbcr_pkg::ST_SWEEP && !cur_used)
        |=> (state_reg == tlbcr_pkg::ST_FINISH && !cur_used))
    else $error("sweep stopped on a slot that still had its second chance");

    // No evicted page is reported without an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !res_ev_valid_reg) |-> (res_ev_page_reg == '0))
    else $error("evicted page reported without a valid eviction");

    // A mark result never reports an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlbcr_pkg::ST_FINISH && out_free && cmd_reg == tlbcr_pkg::CMD_MARK)
        |=> (m_tvalid_reg && !res_ev_valid_reg))
    else $error("mark request reported an eviction");

endmodule
